[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is low
`define DIVTIM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check that also runs during reset
`define DIVTIM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/divtim_pkg.sv]
// types, constants and helpers for the divider and reloading timer
// no dependencies
package divtim_pkg;

    localparam int PRESCALER_BITS_DEF = 11;
    localparam int DIV_PRESC_BITS     = 9;
    localparam int DIV_PERIOD         = 256;
    localparam int PERIOD_BITS        = 11;
    localparam int CFG_IDX_BITS       = 2;
    localparam int CFG_DATA_BITS      = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOCK_SELECT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELOAD_VALUE = 2'd2;

    localparam logic [1:0] SEL_1024 = 2'd0;
    localparam logic [1:0] SEL_16   = 2'd1;
    localparam logic [1:0] SEL_64   = 2'd2;
    localparam logic [1:0] SEL_256  = 2'd3;

    typedef struct packed {
        logic [7:0] elapsed_cycles;
        logic       restart_prescaler;
    } t_req;

    typedef struct packed {
        logic [7:0] divider_value;
        logic [7:0] counter_value;
        logic       overflow_irq;
    } t_rsp;

    typedef struct packed {
        logic       timer_enable;
        logic [1:0] clock_select;
        logic [7:0] reload_value;
    } t_cfg;

    typedef struct packed {
        logic [7:0] count;
        logic       irq;
    } t_cnt_res;

    function automatic logic [PERIOD_BITS-1:0] period_of(input logic [1:0] sel);
        logic [PERIOD_BITS-1:0] p;
        case (sel)
            SEL_1024: p = 11'd1024;
            SEL_16:   p = 11'd16;
            SEL_64:   p = 11'd64;
            SEL_256:  p = 11'd256;
            default:  p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

[rtl/divtim_if.sv]
// valid/ready channel interfaces for requests and results
// depends on divtim_pkg
interface divtim_req_if;
    logic              valid;
    logic              ready;
    divtim_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface divtim_rsp_if;
    logic              valid;
    logic              ready;
    divtim_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/divtim_div.sv]
// free-running divider: 9-bit prescaler and 8-bit count
// depends on divtim_pkg
module divtim_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_cycles,
    output logic [7:0] o_count
);
    localparam int SB = divtim_pkg::DIV_PRESC_BITS;

    logic [SB-1:0] r_presc, n_presc;
    logic [7:0]    r_count, n_count;
    logic [SB:0]   sum;

    always_comb begin
        sum     = {1'b0, r_presc} + (SB + 1)'(i_cycles);
        n_count = r_count;
        if (sum >= (SB + 1)'(divtim_pkg::DIV_PERIOD)) begin
            sum     = sum - (SB + 1)'(divtim_pkg::DIV_PERIOD);
            n_count = r_count + 8'd1;
        end
        n_presc = sum[SB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_presc <= n_presc;
            r_count <= n_count;
        end
    end

    assign o_count = n_count;
endmodule

[rtl/divtim_cnt.sv]
// selectable-rate counter with saturating prescaler, reload and restart hold
// depends on divtim_pkg
module divtim_cnt #(
    parameter int PRESCALER_BITS = divtim_pkg::PRESCALER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_cycles,
    input  logic                  i_restart,
    input  divtim_pkg::t_cfg      i_cfg,
    output divtim_pkg::t_cnt_res  o_res
);
    localparam int PB = PRESCALER_BITS;
    localparam logic [PB:0] SumMax = {1'b0, {PB{1'b1}}};

    logic [PB-1:0] r_presc, n_presc;
    logic [7:0]    r_count, n_count;
    logic          r_pend, n_pend;
    logic [PB-1:0] base, sat, period;
    logic [PB:0]   sum;
    logic          irq;

    always_comb begin
        n_pend  = r_pend | i_restart;
        n_presc = r_presc;
        n_count = r_count;
        irq     = 1'b0;
        base    = r_presc;
        period  = PB'(divtim_pkg::period_of(i_cfg.clock_select));
        sum     = '0;
        sat     = '0;
        if (i_cfg.timer_enable) begin
            if (n_pend) begin
                base = '0;
            end
            n_pend  = 1'b0;
            sum     = {1'b0, base} + (PB + 1)'(i_cycles);
            sat     = (sum > SumMax) ? SumMax[PB-1:0] : sum[PB-1:0];
            n_presc = sat;
            if (sat >= period) begin
                n_presc = sat - period;
                if (r_count == 8'hFF) begin
                    n_count = i_cfg.reload_value;
                    irq     = 1'b1;
                end else begin
                    n_count = r_count + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else if (i_step) begin
            r_presc <= n_presc;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    assign o_res.count = n_count;
    assign o_res.irq   = irq;
endmodule

[rtl/divider_and_reloading_timer_core.sv]
// top level of the divider and reloading timer
// depends on divtim_pkg, divtim_if, divtim_div, divtim_cnt
//
//  channel    dir   payload                                        accept
//  i_req_ch   in    elapsed_cycles, restart_prescaler              valid && ready
//  o_res_ch   out   divider_value, counter_value, overflow_irq     valid && ready
//  i_cfg_*    in    index 0 enable, 1 clock select, 2 reload       i_cfg_we
//
// one request per cycle sustained while results are taken
// request register feeds one add-saturate-compare-subtract pass into the result register
// synchronous active-low reset clears state, config and both valid flags
// a stalled result holds; the request register still drains while the result is taken
module divider_and_reloading_timer_core #(
    parameter int PRESCALER_BITS = divtim_pkg::PRESCALER_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    divtim_req_if.sink                           i_req_ch,
    divtim_rsp_if.source                         o_res_ch,
    input  logic                                 i_cfg_we,
    input  logic [divtim_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [divtim_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    divtim_pkg::t_cfg     r_cfg;
    divtim_pkg::t_req     r_req;
    logic                 r_req_valid;
    divtim_pkg::t_rsp     r_rsp;
    logic                 r_rsp_valid;
    logic                 advance;
    logic [7:0]           div_next;
    divtim_pkg::t_cnt_res cnt_next;

    assign advance        = r_req_valid && (!r_rsp_valid || o_res_ch.ready);
    assign i_req_ch.ready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                divtim_pkg::CFG_TIMER_ENABLE: r_cfg.timer_enable <= i_cfg_wdata[0];
                divtim_pkg::CFG_CLOCK_SELECT: r_cfg.clock_select <= i_cfg_wdata[1:0];
                divtim_pkg::CFG_RELOAD_VALUE: r_cfg.reload_value <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req_ch.ready) begin
            r_req_valid <= i_req_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_ch.valid && i_req_ch.ready) begin
            r_req <= i_req_ch.payload;
        end
    end

    divtim_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_cycles (r_req.elapsed_cycles),
        .o_count  (div_next)
    );

    divtim_cnt #(
        .PRESCALER_BITS (PRESCALER_BITS)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_cycles  (r_req.elapsed_cycles),
        .i_restart (r_req.restart_prescaler),
        .i_cfg     (r_cfg),
        .o_res     (cnt_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rsp.divider_value <= div_next;
            r_rsp.counter_value <= cnt_next.count;
            r_rsp.overflow_irq  <= cnt_next.irq;
        end
    end

    assign o_res_ch.valid   = r_rsp_valid;
    assign o_res_ch.payload = r_rsp;
endmodule

[rtl/divtim_checker.sv]
// port-level checks for the divider and reloading timer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module divtim_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_div,
    input logic [7:0] i_cnt,
    input logic       i_irq
);
    `DIVTIM_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `DIVTIM_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_div) && $stable(i_cnt) && $stable(i_irq)), "stalled result changed")

    `DIVTIM_ASSERT(a_backpressure_cause, i_clk, i_rst_n, !i_in_ready |-> (i_out_valid && !i_out_ready), "request stalled without a blocked result")

    `DIVTIM_ASSERT(a_divider_steps_one, i_clk, i_rst_n, ((i_out_valid && i_out_ready) ##1 i_out_valid) |-> (i_div == $past(i_div) || i_div == $past(i_div) + 8'd1), "divider jumped by more than one")
endmodule

bind divider_and_reloading_timer_core divtim_checker u_divtim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req_ch.ready),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_div       (o_res_ch.payload.divider_value),
    .i_cnt       (o_res_ch.payload.counter_value),
    .i_irq       (o_res_ch.payload.overflow_irq)
);

[test/tb.sv]
`timescale 1ns / 100ps
// testbench for divider_and_reloading_timer_core: directed and random step reports
// checked against a cycle-count model of the divider and the reloading counter
// depends on divtim_pkg, divtim_if and the core rtl
module tb;
    localparam int PRESC_BITS = divtim_pkg::PRESCALER_BITS_DEF;
    localparam int unsigned PRESC_MAX = (1 << PRESC_BITS) - 1;
    localparam logic [divtim_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [divtim_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [divtim_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata;

    divtim_req_if req_ch();
    divtim_rsp_if rsp_ch();

    divider_and_reloading_timer_core #(
        .PRESCALER_BITS(PRESC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_ch   (req_ch),
        .o_res_ch   (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    bit tm_enable = 1'b0;
    bit [1:0] tm_select = divtim_pkg::SEL_1024;
    bit [7:0] tm_reload = 8'd0;
    int unsigned div_presc = 0;
    bit [7:0] div_count = 8'd0;
    int unsigned cnt_presc = 0;
    bit [7:0] cnt_count = 8'd0;
    bit restart_pend = 1'b0;

    divtim_pkg::t_rsp readings_due[$];
    int bad_readings = 0;
    int req_idle_pct = 0;
    int rsp_stall_pct = 0;
    logic rsp_hold;
    int quiet_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic divtim_pkg::t_rsp advance_timers(input divtim_pkg::t_req step);
        divtim_pkg::t_rsp reading;
        int unsigned period;
        int unsigned sum;
        div_presc = div_presc + step.elapsed_cycles;
        if (div_presc >= 256) begin
            div_presc = div_presc - 256;
            div_count = div_count + 8'd1;
        end
        if (step.restart_prescaler) begin
            restart_pend = 1'b1;
        end
        reading.overflow_irq = 1'b0;
        if (tm_enable) begin
            case (tm_select)
                divtim_pkg::SEL_1024: period = 1024;
                divtim_pkg::SEL_16:   period = 16;
                divtim_pkg::SEL_64:   period = 64;
                divtim_pkg::SEL_256:  period = 256;
                default:              period = 1024;
            endcase
            if (restart_pend) begin
                restart_pend = 1'b0;
                cnt_presc = 0;
            end
            sum = cnt_presc + step.elapsed_cycles;
            cnt_presc = (sum > PRESC_MAX) ? PRESC_MAX : sum;
            if (cnt_presc >= period) begin
                cnt_presc = cnt_presc - period;
                cnt_count = cnt_count + 8'd1;
                if (cnt_count == 8'd0) begin
                    reading.overflow_irq = 1'b1;
                    cnt_count = tm_reload;
                end
            end
        end
        reading.divider_value = div_count;
        reading.counter_value = cnt_count;
        return reading;
    endfunction

    function automatic divtim_pkg::t_req mk_step(input logic [7:0] cycles, input logic restart);
        divtim_pkg::t_req step;
        step.elapsed_cycles = cycles;
        step.restart_prescaler = restart;
        return step;
    endfunction

    function automatic divtim_pkg::t_req random_step();
        divtim_pkg::t_req step;
        case ($urandom_range(9))
            0, 1, 2, 3: step.elapsed_cycles = 8'($urandom_range(255));
            4, 5:       step.elapsed_cycles = $urandom_range(1) ? 8'hFF : 8'h00;
            default:    step.elapsed_cycles = 8'($urandom_range(24));
        endcase
        step.restart_prescaler = ($urandom_range(15) == 0);
        return step;
    endfunction

    task automatic issue_step(input divtim_pkg::t_req step);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= step;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        readings_due.push_back(advance_timers(step));
    endtask

    task automatic drain_readings();
        req_ch.valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [divtim_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            divtim_pkg::CFG_TIMER_ENABLE: tm_enable = data[0];
            divtim_pkg::CFG_CLOCK_SELECT: tm_select = data[1:0];
            divtim_pkg::CFG_RELOAD_VALUE: tm_reload = data;
            default: ;
        endcase
    endtask

    task automatic program_timer(input logic [7:0] en_raw, input logic [7:0] sel_raw,
                                 input logic [7:0] reload_raw);
        write_reg(divtim_pkg::CFG_TIMER_ENABLE, en_raw);
        write_reg(divtim_pkg::CFG_CLOCK_SELECT, sel_raw);
        write_reg(divtim_pkg::CFG_RELOAD_VALUE, reload_raw);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // timer off, upper bits of the enable write must be dropped
    task automatic test_divider_only();
        program_timer(8'hFE, {6'h3F, divtim_pkg::SEL_1024}, 8'h00);
        issue_step(mk_step(8'd0, 1'b0));
        issue_step(mk_step(8'd255, 1'b0));
        issue_step(mk_step(8'd255, 1'b1));
        issue_step(mk_step(8'd2, 1'b0));
        issue_step(mk_step(8'd255, 1'b0));
        issue_step(mk_step(8'd128, 1'b0));
        drain_readings();
    endtask

    // restart held while off is applied on the first enabled step
    task automatic test_restart_on_enable();
        program_timer(8'h01, {6'h3F, divtim_pkg::SEL_64}, 8'h80);
        issue_step(mk_step(8'd0, 1'b0));
        issue_step(mk_step(8'd64, 1'b1));
        issue_step(mk_step(8'd63, 1'b0));
        issue_step(mk_step(8'd1, 1'b0));
        issue_step(mk_step(8'd255, 1'b0));
        drain_readings();
        write_reg(CFG_UNUSED, 8'hFF);
        i_cfg_we <= 1'b0;
        issue_step(mk_step(8'd16, 1'b0));
        drain_readings();
    endtask

    // short period with long steps builds a backlog up to the prescaler limit
    task automatic test_backlog_saturation();
        program_timer(8'h01, {6'h00, divtim_pkg::SEL_16}, 8'hFF);
        repeat (12) issue_step(mk_step(8'd255, 1'b0));
        drain_readings();
        program_timer(8'h01, {6'h00, divtim_pkg::SEL_1024}, 8'h00);
        issue_step(mk_step(8'd0, 1'b0));
        drain_readings();
    endtask

    task automatic test_random_phases();
        logic [7:0] en_raw;
        logic [7:0] sel_raw;
        logic [7:0] rel_raw;
        for (int ph = 0; ph < 10; ph++) begin
            en_raw = 8'($urandom);
            sel_raw = 8'($urandom);
            rel_raw = 8'($urandom);
            case (ph)
                0: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_16; rel_raw = 8'hFF; end
                1: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_16; end
                2: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_64; rel_raw = 8'hF0; end
                3: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_256; rel_raw = 8'h00; end
                4: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_1024; end
                5: en_raw[0] = 1'b0;
                6: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_16; rel_raw = 8'hFC; end
                7: en_raw[0] = 1'b1;
                8: begin en_raw[0] = 1'b1; sel_raw[1:0] = divtim_pkg::SEL_64; rel_raw = 8'hFF; end
                default: ;
            endcase
            program_timer(en_raw, sel_raw, rel_raw);
            case (ph % 4)
                0: begin req_idle_pct = 0; rsp_stall_pct = 0; end
                1: begin req_idle_pct = 69; rsp_stall_pct = 0; end
                2: begin req_idle_pct = 0; rsp_stall_pct = 69; end
                default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
            endcase
            repeat (125) issue_step(random_step());
            drain_readings();
        end
        req_idle_pct = 0;
        rsp_stall_pct = 0;
    endtask

    // results held off while requests keep coming, then a full drain
    task automatic test_backpressure();
        program_timer(8'h01, {6'h00, divtim_pkg::SEL_16}, 8'hFE);
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rsp_hold <= 1'b0;
            end
            begin
                repeat (40) issue_step(random_step());
            end
        join
        drain_readings();
    endtask

    always @(posedge i_clk) begin : check_readings
        divtim_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (readings_due.size() == 0) begin
                $display("%0t: result with no request pending, got %h", $time,
                         rsp_ch.payload);
                bad_readings++;
            end else begin
                want = readings_due.pop_front();
                if (rsp_ch.payload.divider_value !== want.divider_value) begin
                    $display("%0t: divider_value expected %0d got %0d", $time,
                             want.divider_value, rsp_ch.payload.divider_value);
                    bad_readings++;
                end
                if (rsp_ch.payload.counter_value !== want.counter_value) begin
                    $display("%0t: counter_value expected %0d got %0d", $time,
                             want.counter_value, rsp_ch.payload.counter_value);
                    bad_readings++;
                end
                if (rsp_ch.payload.overflow_irq !== want.overflow_irq) begin
                    $display("%0t: overflow_irq expected %0d got %0d", $time,
                             want.overflow_irq, rsp_ch.payload.overflow_irq);
                    bad_readings++;
                end
            end
        end
        rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("divider_and_reloading_timer_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        rsp_hold <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= divtim_pkg::CFG_TIMER_ENABLE;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_divider_only();
        test_restart_on_enable();
        test_backlog_saturation();
        test_random_phases();
        test_backpressure();
        drain_readings();
        repeat (10) @(posedge i_clk);
        if (bad_readings == 0) begin
            $display("divider_and_reloading_timer_core test passed");
        end else begin
            $display("divider_and_reloading_timer_core test failed");
        end
        $finish;
    end
endmodule
